// ===== hw/rtl/separable_gaussian_blur_core_macros.svh =====
// ============================================================================
// Assertion macros for the separable Gaussian blur core
// Short forms for the concurrent checks that the core carries.
// ============================================================================
`ifndef SEPARABLE_GAUSSIAN_BLUR_CORE_MACROS_SVH
`define SEPARABLE_GAUSSIAN_BLUR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgb assertion failed");

`endif

// ===== hw/rtl/sgb_pkg.sv =====
// ============================================================================
// Separable Gaussian blur package
// Word types, register indexes and the controller/datapath interface.
// ============================================================================
package sgb_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int DIM_W      = 13;
    localparam int ROW_W      = 12;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    typedef struct packed {
        logic       command;
        logic [7:0] sample_a;
        logic [7:0] sample_b;
        logic [7:0] sample_c;
        logic [7:0] sample_d;
    } t_in_word;

    typedef struct packed {
        logic [7:0] blur_a;
        logic [7:0] blur_b;
        logic [7:0] blur_c;
        logic [7:0] blur_d;
        logic       frame_end;
    } t_out_word;

    typedef enum logic {
        MODE_H,
        MODE_V
    } t_mode;

    typedef struct packed {
        logic  latch;
        logic  win_wr;
        logic  hx_first;
        logic  hx_tail;
        logic  hx_next;
        logic  issue;
        t_mode mode;
        logic  acc_clr;
        logic  acc_en;
        logic  ring_wr;
        logic  pos_upd;
        logic  out_ld;
    } t_cmd;

    typedef struct packed {
        logic pixel_go;
        logic col_ge_r;
        logic col_last;
        logic hx_last;
        logic ready;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/sgb_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module sgb_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sgb_datapath.sv =====
// ============================================================================
// Separable Gaussian blur datapath
// Configuration, position counters, line stores and the shared tap MAC.
// ============================================================================
module sgb_datapath #(
    parameter int  RADIUS    = 10,
    parameter int  MAX_WIDTH = 1024,
    localparam int TAPS      = 2 * RADIUS + 1,
    localparam int TAP_W     = $clog2(TAPS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sgb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sgb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  sgb_pkg::t_in_word             i_in_word,
    input  sgb_pkg::t_cmd                 i_cmd,
    input  logic [TAP_W-1:0]              i_tap,
    output sgb_pkg::t_sts                 o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sgb_pkg::t_out_word            o_out_word
);

    localparam int WIN_AW = $clog2(TAPS);
    localparam int RING_D = TAPS * MAX_WIDTH;
    localparam int RING_AW = $clog2(RING_D);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int ACC_W = 25;
    localparam logic [15:0] RECIP = 16'(65536 / TAPS);

    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [TAPS*16-1:0] build_weights();
        logic [63:0] u, e, term, a, s, w, q;
        logic [63:0] g [RADIUS+1];
        logic [TAPS*16-1:0] res;
        u    = div_u64(64'd2 << 30, 64'(RADIUS * RADIUS));
        e    = 64'd1 << 30;
        term = 64'd1 << 30;
        res  = '0;
        for (int k = 1; k < 64; k++) begin
            if (term != 0) begin
                term = div_u64((term * u) >> 30, 64'(k));
                e    = e + term;
            end
        end
        a = div_u64((64'd1 << 60) + (e >> 1), e);
        s = 0;
        for (int i = 0; i <= RADIUS; i++) begin
            w = 64'd1 << 30;
            for (int n = 0; n < i * i; n++) begin
                w = (w * a + (64'd1 << 29)) >> 30;
            end
            g[i] = w;
            s = s + ((i == 0) ? w : 2 * w);
        end
        for (int i = 0; i <= RADIUS; i++) begin
            q = div_u64(g[i] * 64'd65536 + (s >> 1), s);
            res[(RADIUS+i)*16 +: 16] = q[15:0];
            res[(RADIUS-i)*16 +: 16] = q[15:0];
        end
        return res;
    endfunction

    localparam logic [TAPS*16-1:0] WEIGHTS = build_weights();

    function automatic logic [WIN_AW-1:0] mod_taps(input logic [11:0] x);
        logic [27:0] p;
        logic [11:0] r;
        p = 28'(x) * 28'(RECIP);
        r = x - 12'(p[27:16] * TAPS);
        if (r >= 12'(TAPS)) begin
            r = r - 12'(TAPS);
        end
        return r[WIN_AW-1:0];
    endfunction

    function automatic logic [7:0] sat8(input logic [ACC_W-1:0] acc);
        logic [8:0] v;
        v = acc[ACC_W-1:16];
        return (v > 9'd255) ? 8'hff : v[7:0];
    endfunction

    logic [10:0]      r_frame_width;
    logic [12:0]      r_frame_height;
    logic [2:0]       r_channel_count;
    logic [CW-1:0]    r_in_col, r_out_col, r_hx;
    logic [11:0]      r_in_row, r_out_row;
    logic             r_draining, r_cmd_bit, r_out_valid;
    logic [31:0]      r_word;
    logic [TAP_W-1:0] r_tap_d;
    sgb_pkg::t_mode   r_mode_d;
    logic [ACC_W-1:0] r_acc [4];
    sgb_pkg::t_out_word r_out_word;

    logic [12:0]        w_eff, h_eff, wm1, hm1, ry, cx;
    logic [2:0]         ch_eff;
    logic [CW-1:0]      col, oc;
    logic [11:0]        row, orow, jclamp, rclamp;
    logic signed [14:0] jt, rt;
    logic [25:0]        have, need;
    logic [7:0]         smp [4];
    logic [7:0]         sat [4];
    logic [31:0]        win_rdata, ring_rdata, rd_word;
    logic [WIN_AW-1:0]  win_waddr, win_raddr;
    logic [RING_AW-1:0] ring_waddr, ring_raddr;
    logic [15:0]        wgt;
    logic               last;

    assign smp[0] = i_in_word.sample_a;
    assign smp[1] = i_in_word.sample_b;
    assign smp[2] = i_in_word.sample_c;
    assign smp[3] = i_in_word.sample_d;

    always_comb begin
        w_eff = {2'b00, r_frame_width};
        if (w_eff == 13'd0) begin
            w_eff = 13'd1;
        end else if (w_eff > 13'(MAX_WIDTH)) begin
            w_eff = 13'(MAX_WIDTH);
        end
        h_eff = r_frame_height;
        if (h_eff == 13'd0) begin
            h_eff = 13'd1;
        end else if (h_eff > 13'(sgb_pkg::MAX_HEIGHT)) begin
            h_eff = 13'(sgb_pkg::MAX_HEIGHT);
        end
        ch_eff = r_channel_count;
        if (ch_eff == 3'd0) begin
            ch_eff = 3'd1;
        end else if (ch_eff > 3'd4) begin
            ch_eff = 3'd4;
        end
        wm1  = w_eff - 13'd1;
        hm1  = h_eff - 13'd1;
        col  = (13'(r_in_col) > wm1) ? wm1[CW-1:0] : r_in_col;
        row  = (r_in_row > hm1[11:0]) ? hm1[11:0] : r_in_row;
        oc   = (13'(r_out_col) > wm1) ? wm1[CW-1:0] : r_out_col;
        orow = (r_out_row > hm1[11:0]) ? hm1[11:0] : r_out_row;

        jt = $signed(15'(r_hx)) + $signed(15'(i_tap)) - $signed(15'(RADIUS));
        if (jt < 0) begin
            jclamp = 12'd0;
        end else if (jt > $signed({2'b00, wm1})) begin
            jclamp = wm1[11:0];
        end else begin
            jclamp = jt[11:0];
        end
        rt = $signed(15'(orow)) + $signed(15'(i_tap)) - $signed(15'(RADIUS));
        if (rt < 0) begin
            rclamp = 12'd0;
        end else if (rt > $signed({2'b00, hm1})) begin
            rclamp = hm1[11:0];
        end else begin
            rclamp = rt[11:0];
        end

        win_waddr  = mod_taps(12'(col));
        win_raddr  = mod_taps(jclamp);
        ring_waddr = RING_AW'(32'(mod_taps(row)) * 32'(MAX_WIDTH) + 32'(r_hx));
        ring_raddr = RING_AW'(32'(mod_taps(rclamp)) * 32'(MAX_WIDTH) + 32'(oc));

        ry   = (13'(orow) + 13'(RADIUS) > hm1) ? hm1 : 13'(orow) + 13'(RADIUS);
        cx   = (13'(oc) + 13'(RADIUS) > wm1) ? wm1 : 13'(oc) + 13'(RADIUS);
        have = 26'(r_in_row) * 26'(w_eff) + 26'(r_in_col);
        need = 26'(ry) * 26'(w_eff) + 26'(cx);
        last = (13'(oc) == wm1) && (13'(orow) == hm1);

        rd_word = (r_mode_d == sgb_pkg::MODE_H) ? win_rdata : ring_rdata;
        wgt     = WEIGHTS[r_tap_d*16 +: 16];
        for (int c = 0; c < 4; c++) begin
            sat[c] = sat8(r_acc[c]);
        end
    end

    sgb_ram #(.WIDTH(32), .DEPTH(TAPS)) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.win_wr),
        .i_waddr (win_waddr),
        .i_wdata (r_word),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

    sgb_ram #(.WIDTH(32), .DEPTH(RING_D)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ring_wr),
        .i_waddr (ring_waddr),
        .i_wdata ({sat[3], sat[2], sat[1], sat[0]}),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= 11'd640;
            r_frame_height  <= 13'd480;
            r_channel_count <= 3'd3;
            r_in_col        <= '0;
            r_in_row        <= '0;
            r_out_col       <= '0;
            r_out_row       <= '0;
            r_draining      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sgb_pkg::CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data[10:0];
                    sgb_pkg::CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data;
                    sgb_pkg::CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_cmd.pos_upd) begin
                if (13'(col) == wm1) begin
                    r_in_col <= '0;
                    if (13'(row) == hm1) begin
                        r_in_row   <= '0;
                        r_draining <= 1'b1;
                    end else begin
                        r_in_row <= row + 12'd1;
                    end
                end else begin
                    r_in_col <= col + CW'(1);
                    r_in_row <= row;
                end
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
                if (last) begin
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_draining <= 1'b0;
                end else if (13'(oc) == wm1) begin
                    r_out_col <= '0;
                    r_out_row <= orow + 12'd1;
                end else begin
                    r_out_col <= oc + CW'(1);
                    r_out_row <= orow;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd_bit <= i_in_word.command;
            for (int c = 0; c < 4; c++) begin
                r_word[8*c +: 8] <= (3'(c) < ch_eff) ? smp[c] : 8'd0;
            end
        end
        if (i_cmd.hx_first) begin
            r_hx <= CW'(13'(col) - 13'(RADIUS));
        end else if (i_cmd.hx_tail) begin
            r_hx <= (w_eff >= 13'(RADIUS)) ? CW'(w_eff - 13'(RADIUS)) : '0;
        end else if (i_cmd.hx_next) begin
            r_hx <= r_hx + CW'(1);
        end
        if (i_cmd.issue) begin
            r_tap_d  <= i_tap;
            r_mode_d <= i_cmd.mode;
        end
        for (int c = 0; c < 4; c++) begin
            if (i_cmd.acc_clr) begin
                r_acc[c] <= '0;
            end else if (i_cmd.acc_en) begin
                r_acc[c] <= r_acc[c] + ACC_W'(wgt) * ACC_W'(rd_word[8*c +: 8]);
            end
        end
        if (i_cmd.out_ld) begin
            r_out_word.blur_a    <= sat[0];
            r_out_word.blur_b    <= (ch_eff > 3'd1) ? sat[1] : 8'd0;
            r_out_word.blur_c    <= (ch_eff > 3'd2) ? sat[2] : 8'd0;
            r_out_word.blur_d    <= (ch_eff > 3'd3) ? sat[3] : 8'd0;
            r_out_word.frame_end <= last;
        end
    end

    assign o_sts.pixel_go = !r_cmd_bit && !r_draining;
    assign o_sts.col_ge_r = 13'(col) >= 13'(RADIUS);
    assign o_sts.col_last = 13'(col) == wm1;
    assign o_sts.hx_last  = 13'(r_hx) == wm1;
    assign o_sts.ready    = r_draining || (have > need);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_word     = r_out_word;

endmodule

// ===== hw/rtl/sgb_controller.sv =====
// ============================================================================
// Separable Gaussian blur controller
// Sequences window writes, horizontal and vertical tap passes and output.
// ============================================================================
module sgb_controller #(
    parameter int  RADIUS = 10,
    localparam int TAPS   = 2 * RADIUS + 1,
    localparam int TAP_W  = $clog2(TAPS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  sgb_pkg::t_sts    i_sts,
    output sgb_pkg::t_cmd    o_cmd,
    output logic [TAP_W-1:0] o_tap
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_HCHK, S_TCHK, S_HMAC, S_HWR, S_POS, S_RDY, S_VMAC, S_VOUT
    } t_state;

    t_state           r_state;
    logic [TAP_W-1:0] r_tap;
    logic             r_tail;
    logic             tap_end;

    assign tap_end = r_tap == TAP_W'(TAPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_tail  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_DEC;
                S_DEC:  r_state <= i_sts.pixel_go ? S_HCHK : S_RDY;
                S_HCHK: begin
                    if (i_sts.col_ge_r) begin
                        r_tail  <= 1'b0;
                        r_tap   <= '0;
                        r_state <= S_HMAC;
                    end else begin
                        r_state <= S_TCHK;
                    end
                end
                S_TCHK: begin
                    if (i_sts.col_last) begin
                        r_tail  <= 1'b1;
                        r_tap   <= '0;
                        r_state <= S_HMAC;
                    end else begin
                        r_state <= S_POS;
                    end
                end
                S_HMAC: begin
                    if (tap_end) r_state <= S_HWR;
                    else         r_tap   <= r_tap + TAP_W'(1);
                end
                S_HWR: begin
                    if (!r_tail) begin
                        r_state <= S_TCHK;
                    end else if (!i_sts.hx_last) begin
                        r_tap   <= '0;
                        r_state <= S_HMAC;
                    end else begin
                        r_state <= S_POS;
                    end
                end
                S_POS: r_state <= S_RDY;
                S_RDY: begin
                    if (i_sts.ready) begin
                        r_tap   <= '0;
                        r_state <= S_VMAC;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_VMAC: begin
                    if (tap_end) r_state <= S_VOUT;
                    else         r_tap   <= r_tap + TAP_W'(1);
                end
                S_VOUT: if (i_sts.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.mode = (r_state == S_VMAC) ? sgb_pkg::MODE_V : sgb_pkg::MODE_H;
        unique case (r_state)
            S_IDLE: o_cmd.latch    = i_in_valid;
            S_DEC:  o_cmd.win_wr   = i_sts.pixel_go;
            S_HCHK: o_cmd.hx_first = i_sts.col_ge_r;
            S_TCHK: o_cmd.hx_tail  = i_sts.col_last;
            S_HMAC, S_VMAC: begin
                o_cmd.issue   = !tap_end;
                o_cmd.acc_clr = r_tap == '0;
                o_cmd.acc_en  = r_tap != '0;
            end
            S_HWR: begin
                o_cmd.ring_wr = 1'b1;
                o_cmd.hx_next = r_tail && !i_sts.hx_last;
            end
            S_POS:  o_cmd.pos_upd = 1'b1;
            S_VOUT: o_cmd.out_ld  = i_sts.out_free;
            default: ;
        endcase
    end

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
    assign o_tap      = r_tap;

endmodule

// ===== hw/rtl/separable_gaussian_blur_core.sv =====
// ============================================================================
// Separable Gaussian blur core
// Clamp-to-edge Gaussian blur of raster pixels, horizontal then vertical.
//
//   channel   direction   signals                                  payload
//   input     in          i_in_valid / o_in_stall / i_in_word      t_in_word
//   output    out         o_out_valid / i_out_stall / o_out_word   t_out_word
//   config    in          i_cfg_we / i_cfg_idx / i_cfg_data        register write
//
// One word is in work at a time on a single shared tap MAC. A flush word runs
// no horizontal pass; a pixel runs one horizontal pass per column it finishes
// (up to RADIUS+1 of them at a row end), and one vertical pass follows when a
// vertical result is released.
// Reset is synchronous and active low; line stores are not cleared.
// A stalled output holds the controller only once the next result is ready.
// ============================================================================
`include "separable_gaussian_blur_core_macros.svh"

module separable_gaussian_blur_core #(
    parameter int RADIUS    = 10,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sgb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sgb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sgb_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sgb_pkg::t_out_word             o_out_word
);

    localparam int TAPS  = 2 * RADIUS + 1;
    localparam int TAP_W = $clog2(TAPS + 1);

    sgb_pkg::t_cmd    cmd;
    sgb_pkg::t_sts    sts;
    logic [TAP_W-1:0] tap;

    sgb_controller #(.RADIUS(RADIUS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_tap      (tap)
    );

    sgb_datapath #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .i_tap       (tap),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    `SGB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `SGB_ASSERT_IMPL(a_load_only_when_free, i_clk, i_rst_n, cmd.out_ld, sts.out_free)
    `SGB_ASSERT_IMPL(a_no_read_on_write, i_clk, i_rst_n, cmd.win_wr || cmd.ring_wr, !cmd.issue)

endmodule
